// File: design/pgcc_pkg.sv
// ----------------------------------------------------------------------------
// pgcc_pkg: shared definitions of the pin-guide connectivity checker
// Operation codes, field widths, register indexes and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pgcc_pkg;

   localparam int PGCC_MAX_PINS   = 16;
   localparam int PGCC_MAX_GUIDES = 64;

   localparam int OP_W          = 2;
   localparam int PIN_IDX_W     = 4;
   localparam int GUIDE_IDX_W   = 6;
   localparam int PIN_COUNT_W   = 5;
   localparam int GUIDE_COUNT_W = 7;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 7;

   localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD_PG   = 2'd1;
   localparam logic [OP_W-1:0] OP_ADD_GG   = 2'd2;
   localparam logic [OP_W-1:0] OP_CHECK    = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_PIN_COUNT   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GUIDE_COUNT = 1'd1;

   typedef struct packed {
      logic capture;
      logic clear;
      logic load_pg;
      logic gg_wr;
      logic gg_second;
      logic check_init;
      logic sweep;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            gg_ok;
      logic            sweep_done;
   } status_type;

endpackage

// File: design/pgcc_channels.sv
// ----------------------------------------------------------------------------
// pgcc channels: valid/ready interfaces of the checker
// Request, response and register write channels, each with a source and a
// sink modport.
// ----------------------------------------------------------------------------
interface pgcc_req_if import pgcc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        operation;
   logic [PIN_IDX_W-1:0]   pin_index;
   logic [GUIDE_IDX_W-1:0] first_guide;
   logic [GUIDE_IDX_W-1:0] second_guide;

   modport source (output valid, operation, pin_index, first_guide, second_guide,
                   input ready);
   modport sink   (input valid, operation, pin_index, first_guide, second_guide,
                   output ready);
endinterface

interface pgcc_rsp_if import pgcc_pkg::*; ();
   logic valid;
   logic ready;
   logic all_pins_connected;
   logic every_pin_has_guide;

   modport source (output valid, all_pins_connected, every_pin_has_guide,
                   input ready);
   modport sink   (input valid, all_pins_connected, every_pin_has_guide,
                   output ready);
endinterface

interface pgcc_csr_if import pgcc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: design/pgcc_ctrl.sv
// ----------------------------------------------------------------------------
// pgcc_ctrl: sequencer of the connectivity checker
// Accepts one request transaction at a time, steps the datapath through a
// clear, edge loads or the reachability sweep; owns the response valid flag.
// ----------------------------------------------------------------------------
module pgcc_ctrl import pgcc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_GG_WR1 = 3'd2;
   localparam logic [2:0] ST_GG_RD2 = 3'd3;
   localparam logic [2:0] ST_GG_WR2 = 3'd4;
   localparam logic [2:0] ST_SWEEP  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (status.op)
               OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end
               OP_ADD_PG: begin
                  cmd.load_pg = 1'b1;
                  state_in    = ST_IDLE;
               end
               OP_ADD_GG: begin
                  // The first row is read in this cycle.
                  state_in = status.gg_ok ? ST_GG_WR1 : ST_IDLE;
               end
               OP_CHECK: begin
                  cmd.check_init = 1'b1;
                  state_in       = ST_SWEEP;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_GG_WR1: begin
            cmd.gg_wr = 1'b1;
            state_in  = ST_GG_RD2;
         end
         ST_GG_RD2: begin
            cmd.gg_second = 1'b1;
            state_in      = ST_GG_WR2;
         end
         ST_GG_WR2: begin
            cmd.gg_wr     = 1'b1;
            cmd.gg_second = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            // The result leaves only once the response register is free.
            if (status.sweep_done && (!rsp_valid_ff || rsp_ready)) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: design/pgcc_dp.sv
// ----------------------------------------------------------------------------
// pgcc_dp: datapath of the connectivity checker
// Holds the count registers, the pin-guide matrix in flip-flops, the
// guide-guide matrix in a memory with row valid bits, and the reached masks
// that grow during a check sweep.
// ----------------------------------------------------------------------------
module pgcc_dp import pgcc_pkg::*; #(
   parameter int MAX_PINS   = PGCC_MAX_PINS,
   parameter int MAX_GUIDES = PGCC_MAX_GUIDES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [OP_W-1:0]         operation,
   input  logic [PIN_IDX_W-1:0]    pin_index,
   input  logic [GUIDE_IDX_W-1:0]  first_guide,
   input  logic [GUIDE_IDX_W-1:0]  second_guide,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   output logic                    all_pins_connected,
   output logic                    every_pin_has_guide
);

   localparam int GA_W = (MAX_GUIDES > 1) ? $clog2(MAX_GUIDES) : 1;

   logic [OP_W-1:0]          op_ff;
   logic [PIN_IDX_W-1:0]     pin_ff;
   logic [GUIDE_IDX_W-1:0]   g1_ff;
   logic [GUIDE_IDX_W-1:0]   g2_ff;
   logic [PIN_COUNT_W-1:0]   pin_count_ff;
   logic [GUIDE_COUNT_W-1:0] guide_count_ff;

   logic [MAX_GUIDES-1:0]    pg_ff [MAX_PINS];
   logic [MAX_GUIDES-1:0]    row_valid_ff;
   logic [MAX_GUIDES-1:0]    gg_mem [MAX_GUIDES];
   logic [MAX_GUIDES-1:0]    rdata_ff;
   logic                     rvalid_ff;

   logic [MAX_PINS-1:0]      rp_ff, rp_in;
   logic [MAX_GUIDES-1:0]    rg_ff, rg_in;
   logic [MAX_GUIDES-1:0]    done_ff;
   logic                     inflight_ff;
   logic                     all_ff, every_ff;

   logic [MAX_PINS-1:0]      pmask;
   logic [MAX_GUIDES-1:0]    gmask;
   logic [MAX_GUIDES-1:0]    row_out;
   logic [MAX_GUIDES-1:0]    pin_reach;
   logic [MAX_GUIDES-1:0]    pend;
   logic [GA_W-1:0]          pick;
   logic [GA_W-1:0]          g1_addr, g2_addr, raddr, waddr;
   logic [MAX_GUIDES-1:0]    wbit, wdata;
   logic                     g1_ok, g2_ok;
   logic                     every_now;

   assign g1_addr = g1_ff[GA_W-1:0];
   assign g2_addr = g2_ff[GA_W-1:0];
   assign g1_ok   = int'(g1_ff) < MAX_GUIDES;
   assign g2_ok   = int'(g2_ff) < MAX_GUIDES;

   assign status.op         = op_ff;
   assign status.gg_ok      = g1_ok && g2_ok;
   assign status.sweep_done = !inflight_ff && (pend == '0) &&
                              (rg_in == rg_ff) && (rp_in == rp_ff);

   assign all_pins_connected  = all_ff;
   assign every_pin_has_guide = every_ff;

   // Counts above the store size clamp naturally, since only stored indices exist.
   always_comb begin
      for (int p = 0; p < MAX_PINS; p++) begin
         pmask[p] = int'(pin_count_ff) > p;
      end
      for (int g = 0; g < MAX_GUIDES; g++) begin
         gmask[g] = int'(guide_count_ff) > g;
      end
   end

   assign row_out = rvalid_ff ? rdata_ff : '0;

   // One sweep round: pins spread to guides, a fetched guide row spreads to
   // guides, and guides already reached pull in the pins they touch.
   always_comb begin
      pin_reach = '0;
      every_now = 1'b1;
      for (int p = 0; p < MAX_PINS; p++) begin
         if (rp_ff[p]) begin
            pin_reach = pin_reach | pg_ff[p];
         end
         rp_in[p] = rp_ff[p] || (pmask[p] && ((pg_ff[p] & rg_ff) != '0));
         if (pmask[p] && ((pg_ff[p] & gmask) == '0)) begin
            every_now = 1'b0;
         end
      end
      rg_in = rg_ff | ((pin_reach | (inflight_ff ? row_out : '0)) & gmask);
   end

   assign pend = rg_ff & ~done_ff;

   always_comb begin
      pick = '0;
      for (int g = MAX_GUIDES - 1; g >= 0; g--) begin
         if (pend[g]) begin
            pick = GA_W'(g);
         end
      end
   end

   always_comb begin
      if (cmd.gg_second) begin
         raddr = g2_addr;
      end else if (cmd.sweep) begin
         raddr = pick;
      end else begin
         raddr = g1_addr;
      end
      waddr    = cmd.gg_second ? g2_addr : g1_addr;
      wbit     = '0;
      wbit[cmd.gg_second ? g1_addr : g2_addr] = 1'b1;
      wdata    = row_out | wbit;
   end

   always_ff @(posedge clock) begin
      if (cmd.gg_wr) begin
         gg_mem[waddr] <= wdata;
      end
      rdata_ff <= gg_mem[raddr];
   end

   always_ff @(posedge clock) begin
      rvalid_ff <= row_valid_ff[raddr];
      if (cmd.capture) begin
         op_ff  <= operation;
         pin_ff <= pin_index;
         g1_ff  <= first_guide;
         g2_ff  <= second_guide;
      end
      if (cmd.load_rsp) begin
         all_ff   <= (rp_ff & pmask) == pmask;
         every_ff <= every_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_count_ff   <= PIN_COUNT_W'(1);
         guide_count_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PIN_COUNT:   pin_count_ff   <= csr_data[PIN_COUNT_W-1:0];
            CSR_GUIDE_COUNT: guide_count_ff <= csr_data[GUIDE_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int p = 0; p < MAX_PINS; p++) begin
            pg_ff[p] <= '0;
         end
         row_valid_ff <= '0;
      end else begin
         if (cmd.load_pg && g1_ok) begin
            for (int p = 0; p < MAX_PINS; p++) begin
               if (int'(pin_ff) == p) begin
                  pg_ff[p][g1_addr] <= 1'b1;
               end
            end
         end
         if (cmd.gg_wr) begin
            row_valid_ff[waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff       <= '0;
         rg_ff       <= '0;
         done_ff     <= '0;
         inflight_ff <= 1'b0;
      end else if (cmd.check_init) begin
         // Only pin 0 is seeded, and only when the net has any pins.
         rp_ff       <= MAX_PINS'(pin_count_ff != '0);
         rg_ff       <= '0;
         done_ff     <= '0;
         inflight_ff <= 1'b0;
      end else if (cmd.sweep) begin
         rp_ff       <= rp_in;
         rg_ff       <= rg_in;
         inflight_ff <= pend != '0;
         if (pend != '0) begin
            done_ff[pick] <= 1'b1;
         end
      end
   end

endmodule

// File: design/pin_guide_connectivity_check_top.sv
// ----------------------------------------------------------------------------
// pin_guide_connectivity_check_top: net connectivity checker
// Loads pin-guide and guide-guide edges and checks that all pins of a net
// are joined through its route guides.
// ----------------------------------------------------------------------------
// Usage:
// The req_ch channel carries one operation per transaction: clear both edge
// stores, add a pin-guide edge, add a guide-guide edge, or run a check. Only
// a check produces a response transaction on rsp_ch, holding the two flags.
// The csr_ch channel writes pin_count (index 0) and guide_count (index 1);
// it is always ready, and the user must see that it is written only while
// the block is idle; the block itself does not enforce this. A clear or a
// pin-guide edge passes through the execute state only; a guide-guide edge
// then does the read-modify-write of two rows of the guide-guide memory,
// which has one read and one write port. A check fetches one reached guide
// row per cycle and may idle while a row returns; the reached guides are at
// most guide_count, capped at 64. The next transaction can be taken in the
// same cycle as the response turns valid.
// Reset clears both edge stores (row valid bits for the guide memory) and
// sets pin_count to 1 and guide_count to 0; no clearing pass is needed.
// A finished result sits in an output register, so new operations are taken
// while it waits; a check that completes while the receiver still stalls the
// previous result holds in its sweep state until the register frees.
// ----------------------------------------------------------------------------
module pin_guide_connectivity_check_top import pgcc_pkg::*; #(
   parameter int MAX_PINS   = PGCC_MAX_PINS,
   parameter int MAX_GUIDES = PGCC_MAX_GUIDES
) (
   input logic        clock,
   input logic        reset,
   pgcc_req_if.sink   req_ch,
   pgcc_rsp_if.source rsp_ch,
   pgcc_csr_if.sink   csr_ch
);

   cmd_type    cmd;
   status_type status;

   assign csr_ch.ready = 1'b1;

   pgcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pgcc_dp #(
      .MAX_PINS   (MAX_PINS),
      .MAX_GUIDES (MAX_GUIDES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .operation           (req_ch.operation),
      .pin_index           (req_ch.pin_index),
      .first_guide         (req_ch.first_guide),
      .second_guide        (req_ch.second_guide),
      .csr_we              (csr_ch.valid),
      .csr_index           (csr_ch.index),
      .csr_data            (csr_ch.data),
      .all_pins_connected  (rsp_ch.all_pins_connected),
      .every_pin_has_guide (rsp_ch.every_pin_has_guide)
   );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the pin-guide connectivity checker
// Loads random nets of pin-guide and guide-guide edges under several pin and
// guide counts and runs checks. A local copy of both edge stores predicts the
// two flags of every check, and each response is compared against them.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import pgcc_pkg::*;

   localparam int CYCLE_LIMIT  = 2000000;
   localparam int SETTLE_TICKS = 100;
   localparam int TARGET_OPS   = 1720;

   typedef struct packed {
      logic [OP_W-1:0]        op;
      logic [PIN_IDX_W-1:0]   pin;
      logic [GUIDE_IDX_W-1:0] g1;
      logic [GUIDE_IDX_W-1:0] g2;
   } net_op_type;

   typedef struct packed {
      logic all_connected;
      logic every_guided;
   } net_flags_type;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pgcc_req_if req_ch ();
   pgcc_rsp_if rsp_ch ();
   pgcc_csr_if csr_ch ();

   pin_guide_connectivity_check_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #2 clock = ~clock;

   // Mirror of the block's edge stores and count registers.
   logic [PGCC_MAX_GUIDES-1:0] pg_rows [PGCC_MAX_PINS];
   logic [PGCC_MAX_GUIDES-1:0] gg_rows [PGCC_MAX_GUIDES];
   logic [PIN_COUNT_W-1:0]     cfg_pins   = 1;
   logic [GUIDE_COUNT_W-1:0]   cfg_guides = 0;

   net_op_type    pending_ops [$];
   net_flags_type expected_flags [$];
   int            ops_pushed   = 0;
   int            ops_accepted = 0;
   int            mismatches   = 0;
   int            cycle_count  = 0;

   function automatic net_flags_type reach_flags();
      int                          np, ng;
      logic [PGCC_MAX_PINS-1:0]    pmask, reached_p, prev_p;
      logic [PGCC_MAX_GUIDES-1:0]  gmask, reached_g, prev_g;
      net_flags_type               flags;
      np = (cfg_pins > PGCC_MAX_PINS) ? PGCC_MAX_PINS : cfg_pins;
      ng = (cfg_guides > PGCC_MAX_GUIDES) ? PGCC_MAX_GUIDES : cfg_guides;
      for (int p = 0; p < PGCC_MAX_PINS; p++) pmask[p] = (p < np);
      for (int g = 0; g < PGCC_MAX_GUIDES; g++) gmask[g] = (g < ng);
      reached_p = '0;
      reached_g = '0;
      if (np > 0) reached_p[0] = 1'b1;
      do begin
         prev_p = reached_p;
         prev_g = reached_g;
         for (int p = 0; p < PGCC_MAX_PINS; p++)
            if (reached_p[p]) reached_g |= pg_rows[p] & gmask;
         for (int g = 0; g < PGCC_MAX_GUIDES; g++)
            if (reached_g[g]) reached_g |= gg_rows[g] & gmask;
         for (int p = 0; p < PGCC_MAX_PINS; p++)
            if (pmask[p] && (pg_rows[p] & reached_g) != '0) reached_p[p] = 1'b1;
      end while (reached_p != prev_p || reached_g != prev_g);
      flags.all_connected = ((reached_p & pmask) == pmask);
      flags.every_guided  = 1'b1;
      for (int p = 0; p < PGCC_MAX_PINS; p++)
         if (pmask[p] && (pg_rows[p] & gmask) == '0) flags.every_guided = 1'b0;
      return flags;
   endfunction

   task automatic apply_op(input net_op_type item);
      case (item.op)
         OP_CLEAR: begin
            for (int p = 0; p < PGCC_MAX_PINS; p++) pg_rows[p] = '0;
            for (int g = 0; g < PGCC_MAX_GUIDES; g++) gg_rows[g] = '0;
         end
         OP_ADD_PG: begin
            pg_rows[item.pin][item.g1] = 1'b1;
         end
         OP_ADD_GG: begin
            gg_rows[item.g1][item.g2] = 1'b1;
            gg_rows[item.g2][item.g1] = 1'b1;
         end
         default: begin
            expected_flags.insert(expected_flags.size(), reach_flags());
         end
      endcase
      ops_accepted++;
   endtask

   initial begin
      for (int p = 0; p < PGCC_MAX_PINS; p++) pg_rows[p] = '0;
      for (int g = 0; g < PGCC_MAX_GUIDES; g++) gg_rows[g] = '0;
   end

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin : req_driver
      static net_op_type drive_op = '0;
      static int         burst_left = 0;
      static int         gap_left = 0;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) apply_op(drive_op);
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            drive_op = pending_ops.pop_front();
            req_ch.valid        <= 1'b1;
            req_ch.operation    <= drive_op.op;
            req_ch.pin_index    <= drive_op.pin;
            req_ch.first_guide  <= drive_op.g1;
            req_ch.second_guide <= drive_op.g2;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 20)
                                                        : $urandom_range(12, 1);
               gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(9, 1);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response monitor and receiver stall pattern.
   always @(posedge clock) begin : rsp_monitor
      static ready_mode_type ready_mode = READY_ALWAYS;
      static int             mode_left = 0;
      static int             ticks = 0;
      net_flags_type         want;
      logic                  take;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_flags.size() == 0) begin
               $display("%0t: unexpected response transaction (%0b %0b)", $time,
                        rsp_ch.all_pins_connected, rsp_ch.every_pin_has_guide);
               mismatches++;
            end else begin
               want = expected_flags.pop_front();
               if (rsp_ch.all_pins_connected !== want.all_connected) begin
                  $display("%0t: all_pins_connected expected %0b actual %0b", $time,
                           want.all_connected, rsp_ch.all_pins_connected);
                  mismatches++;
               end
               if (rsp_ch.every_pin_has_guide !== want.every_guided) begin
                  $display("%0t: every_pin_has_guide expected %0b actual %0b", $time,
                           want.every_guided, rsp_ch.every_pin_has_guide);
                  mismatches++;
               end
            end
         end
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(3, 0));
            mode_left  = $urandom_range(300, 20);
         end else begin
            mode_left--;
         end
         ticks++;
         case (ready_mode)
            READY_ALWAYS: take = 1'b1;
            READY_COIN:   take = ($urandom_range(1, 0) != 0);
            READY_SPARSE: take = ($urandom_range(7, 0) == 0);
            default:      take = (ticks % 5) != 0;
         endcase
         rsp_ch.ready <= take;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic push_op(input logic [OP_W-1:0] op, input int pin, input int g1,
                          input int g2);
      net_op_type item;
      item.op  = op;
      item.pin = PIN_IDX_W'(pin);
      item.g1  = GUIDE_IDX_W'(g1);
      item.g2  = GUIDE_IDX_W'(g2);
      pending_ops.insert(pending_ops.size(), item);
      ops_pushed++;
   endtask

   task automatic push_noise();
      push_op(OP_W'($urandom_range(3, 0)), $urandom, $urandom, $urandom);
   endtask

   // Waits until every transaction is accepted and answered, then lets a
   // trailing edge load finish inside the block.
   task automatic settle();
      do @(posedge clock);
      while (ops_accepted != ops_pushed || expected_flags.size() != 0);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int data);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= CSR_DATA_W'(data);
      do @(posedge clock);
      while (!csr_ch.ready);
      if (index == CSR_PIN_COUNT) cfg_pins = PIN_COUNT_W'(data);
      else cfg_guides = GUIDE_COUNT_W'(data);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_counts(input int pins, input int guides);
      settle();
      write_reg(CSR_PIN_COUNT, pins);
      write_reg(CSR_GUIDE_COUNT, guides);
   endtask

   // One net: mostly a clear, pins on a small chained pool of guides with a
   // few links missing, stray edges, a check, and at times an edge and a check.
   task automatic build_net(input int np, input int ng);
      int pool [6];
      int k;
      if ($urandom_range(9, 0) != 0) push_op(OP_CLEAR, $urandom, $urandom, $urandom);
      k = (ng == 0) ? 1 : $urandom_range((ng < 6) ? ng : 6, 1);
      for (int i = 0; i < k; i++)
         pool[i] = (ng == 0 || $urandom_range(9, 0) == 0) ? $urandom_range(63, 0)
                                                          : $urandom_range(ng - 1, 0);
      for (int p = 0; p < np; p++)
         if ($urandom_range(11, 0) != 0)
            push_op(OP_ADD_PG, p, pool[$urandom_range(k - 1, 0)], $urandom);
      for (int i = 1; i < k; i++)
         if ($urandom_range(9, 0) != 0) begin
            if ($urandom_range(1, 0)) push_op(OP_ADD_GG, $urandom, pool[i - 1], pool[i]);
            else push_op(OP_ADD_GG, $urandom, pool[i], pool[i - 1]);
         end
      repeat ($urandom_range(2, 0))
         push_op(OP_W'($urandom_range(2, 1)), $urandom, $urandom, $urandom);
      push_op(OP_CHECK, $urandom, $urandom, $urandom);
      if ($urandom_range(3, 0) == 0) begin
         push_op(OP_W'($urandom_range(2, 1)), $urandom_range(np > 0 ? np - 1 : 0, 0),
                 pool[$urandom_range(k - 1, 0)], pool[$urandom_range(k - 1, 0)]);
         push_op(OP_CHECK, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      int pins, guides;
      req_ch.valid        = 1'b0;
      req_ch.operation    = OP_CLEAR;
      req_ch.pin_index    = '0;
      req_ch.first_guide  = '0;
      req_ch.second_guide = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = CSR_PIN_COUNT;
      csr_ch.data         = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset counts: one pin, no guides.
      push_op(OP_CHECK, 0, 0, 0);
      push_op(OP_ADD_PG, 0, 0, 63);
      push_op(OP_CHECK, 15, 63, 63);

      set_counts(2, 64);
      push_op(OP_CLEAR, 15, 63, 63);
      push_op(OP_ADD_PG, 0, 0, 0);
      push_op(OP_ADD_PG, 1, 63, 0);
      push_op(OP_CHECK, 0, 0, 0);
      push_op(OP_ADD_GG, 0, 63, 0);
      push_op(OP_CHECK, 0, 0, 0);
      // A repeated edge, a self edge and a pin beyond the count change nothing.
      push_op(OP_ADD_GG, 15, 0, 63);
      push_op(OP_ADD_GG, 0, 5, 5);
      push_op(OP_ADD_PG, 15, 63, 0);
      push_op(OP_CHECK, 0, 0, 0);
      push_op(OP_ADD_GG, 0, 63, 63);
      push_op(OP_ADD_PG, 15, 0, 63);
      push_op(OP_CHECK, 0, 0, 0);

      // No pins at all gives both flags set.
      set_counts(0, 0);
      push_op(OP_CHECK, 0, 0, 0);
      // The stored edges of pin 15 now take effect.
      set_counts(16, 64);
      push_op(OP_CHECK, 0, 0, 0);
      // Counts above the store size are clamped.
      set_counts(31, 127);
      push_op(OP_CHECK, 0, 0, 0);

      while (ops_pushed < TARGET_OPS) begin
         case ($urandom_range(7, 0))
            0: begin pins = 16; guides = 64; end
            1: begin pins = 0; guides = $urandom_range(127, 0); end
            2: begin pins = 31; guides = 127; end
            3: begin pins = 1; guides = $urandom_range(64, 0); end
            4: begin pins = $urandom_range(16, 1); guides = 1; end
            5: begin pins = $urandom_range(31, 17); guides = $urandom_range(127, 65); end
            default: begin pins = $urandom_range(16, 1); guides = $urandom_range(64, 0); end
         endcase
         set_counts(pins, guides);
         // Edges left from the previous counts are checked under the new ones.
         if ($urandom_range(1, 0)) push_op(OP_CHECK, $urandom, $urandom, $urandom);
         repeat ($urandom_range(8, 3)) begin
            if ($urandom_range(9, 0) == 0) push_noise();
            else build_net((pins > PGCC_MAX_PINS) ? PGCC_MAX_PINS : pins,
                           (guides > PGCC_MAX_GUIDES) ? PGCC_MAX_GUIDES : guides);
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: sim.f
design/pgcc_pkg.sv
design/pgcc_channels.sv
design/pgcc_ctrl.sv
design/pgcc_dp.sv
design/pin_guide_connectivity_check_top.sv
bench/tb_top.sv
